/* hw/rtl/cdo_pkg.sv */
// ----------------------------------------------------------------------------
// cdo_pkg
// shared widths, operation codes, calendar tables and sequencer states for
// the calendar date offset block
// ----------------------------------------------------------------------------
package cdo_pkg;

   // field widths of the item channels
   localparam int KIND_W   = 3;
   localparam int DAY_W    = 5;
   localparam int MONTH_W  = 4;
   localparam int YEAR_W   = 12;
   localparam int AMOUNT_W = 16;

   // bits that hold the largest forward day count of a 12-bit year
   localparam int DAY_COUNT_W = 21;

   // divisor width, wide enough for the days of one year
   localparam int DIVR_W = 9;

   localparam int DAYS_PER_YEAR   = 365;
   localparam int MONTHS_PER_YEAR = 12;

   // reciprocal divide: (n * RECIP) >> RECIP_SHIFT is the quotient or one short
   localparam int RECIP_SHIFT = 30;
   localparam int RECIP_W     = 27;
   localparam logic [RECIP_W-1:0] RECIP_DAYS   = 27'd2941758;
   localparam logic [RECIP_W-1:0] RECIP_MONTHS = 27'd89478485;

   // parameter defaults
   localparam int MIN_YEAR_DEF    = 1500;
   localparam int MAX_YEAR_DEF    = 3000;
   localparam int AMOUNT_BITS_DEF = 16;

   // operation codes
   localparam logic [KIND_W-1:0] KIND_ADD_DAYS   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SUB_DAYS   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ADD_MONTHS = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SUB_MONTHS = 3'd3;
   localparam logic [KIND_W-1:0] KIND_ADD_YEARS  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_SUB_YEARS  = 3'd5;

   localparam logic [MONTH_W-1:0] JANUARY  = 4'd1;
   localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
   localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_LOAD,
      ST_DIV,
      ST_DONE
   } cdo_state_type;

   // days in a month, february fixed at 28
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] len;
      case (m) inside
         FEBRUARY:                  len = 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

   // day of year (from 0) on which a month starts
   function automatic logic [DIVR_W-1:0] month_start(input logic [MONTH_W-1:0] m);
      logic [DIVR_W-1:0] s;
      case (m)
         4'd2:    s = 9'd31;
         4'd3:    s = 9'd59;
         4'd4:    s = 9'd90;
         4'd5:    s = 9'd120;
         4'd6:    s = 9'd151;
         4'd7:    s = 9'd181;
         4'd8:    s = 9'd212;
         4'd9:    s = 9'd243;
         4'd10:   s = 9'd273;
         4'd11:   s = 9'd304;
         4'd12:   s = 9'd334;
         default: s = 9'd0;
      endcase
      return s;
   endfunction

endpackage

/* hw/rtl/cdo_if.sv */
// ----------------------------------------------------------------------------
// cdo_if
// valid/ready channels for date request items and date result items
// ----------------------------------------------------------------------------
interface cdo_req_if;
   logic                           valid;
   logic                           ready;
   logic [cdo_pkg::KIND_W-1:0]     kind;
   logic [cdo_pkg::DAY_W-1:0]      day;
   logic [cdo_pkg::MONTH_W-1:0]    month;
   logic [cdo_pkg::YEAR_W-1:0]     year;
   logic [cdo_pkg::AMOUNT_W-1:0]   amount;

   modport source (output valid, kind, day, month, year, amount, input ready);
   modport sink   (input valid, kind, day, month, year, amount, output ready);
endinterface

interface cdo_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [cdo_pkg::DAY_W-1:0]      new_day;
   logic [cdo_pkg::MONTH_W-1:0]    new_month;
   logic [cdo_pkg::YEAR_W-1:0]     new_year;
   logic                           out_of_range;

   modport source (output valid, new_day, new_month, new_year, out_of_range,
                   input ready);
   modport sink   (input valid, new_day, new_month, new_year, out_of_range,
                   output ready);
endinterface

/* hw/rtl/cdo_divider.sv */
// ----------------------------------------------------------------------------
// cdo_divider
// reciprocal-multiply divider for the two calendar divisors, four steps:
// capture, multiply, estimate, one correction
// ----------------------------------------------------------------------------
module cdo_divider #(
   parameter int MAG_W = 22
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [MAG_W-1:0]            dividend,
   input  logic [cdo_pkg::DIVR_W-1:0]  divisor,
   output logic                        done,
   output logic [MAG_W-1:0]            quotient,
   output logic [cdo_pkg::DIVR_W-1:0]  remainder
);

   localparam int PROD_W = MAG_W + cdo_pkg::RECIP_W;
   localparam int REM_W  = cdo_pkg::DIVR_W + 1;

   logic [2:0]                  step_ff, step_in;
   logic                        done_ff, done_in;
   logic [MAG_W-1:0]            num_ff, num_in;
   logic [cdo_pkg::DIVR_W-1:0]  divr_ff, divr_in;
   logic [cdo_pkg::RECIP_W-1:0] recip_ff, recip_in;
   logic [PROD_W-1:0]           prod_ff, prod_in;
   logic [MAG_W-1:0]            quot_ff, quot_in;
   logic [REM_W-1:0]            rem_ff, rem_in;

   logic [MAG_W-1:0]            est_quot;
   logic [REM_W-1:0]            est_rem;
   logic                        over;

   // estimate is exact or one short, so the remainder stays below twice the divisor
   assign est_quot = MAG_W'(prod_ff >> cdo_pkg::RECIP_SHIFT);
   assign est_rem  = REM_W'(num_ff - est_quot * MAG_W'(divr_ff));
   assign over     = rem_ff >= {1'b0, divr_ff};

   always_comb begin
      step_in  = {step_ff[1:0], start};
      done_in  = step_ff[2];
      num_in   = num_ff;
      divr_in  = divr_ff;
      recip_in = recip_ff;
      prod_in  = prod_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      if (start) begin
         num_in   = dividend;
         divr_in  = divisor;
         recip_in = (divisor == cdo_pkg::DIVR_W'(cdo_pkg::DAYS_PER_YEAR)) ?
                    cdo_pkg::RECIP_DAYS : cdo_pkg::RECIP_MONTHS;
      end
      if (step_ff[0]) begin
         prod_in = PROD_W'(num_ff) * PROD_W'(recip_ff);
      end
      if (step_ff[1]) begin
         quot_in = est_quot;
         rem_in  = est_rem;
      end
      if (step_ff[2] && over) begin
         quot_in = quot_ff + MAG_W'(1);
         rem_in  = rem_ff - {1'b0, divr_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
      num_ff   <= num_in;
      divr_ff  <= divr_in;
      recip_ff <= recip_in;
      prod_ff  <= prod_in;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff[cdo_pkg::DIVR_W-1:0];

endmodule

/* hw/rtl/cdo_finish.sv */
// ----------------------------------------------------------------------------
// cdo_finish
// turns quotient and remainder into a date, applies month clamp and year clamp
// ----------------------------------------------------------------------------
module cdo_finish #(
   parameter int MAG_W    = 22,
   parameter int AMT_W    = 16,
   parameter int MIN_YEAR = 1500,
   parameter int MAX_YEAR = 3000
) (
   input  logic [cdo_pkg::KIND_W-1:0]   kind,
   input  logic [cdo_pkg::DAY_W-1:0]    day,
   input  logic [cdo_pkg::MONTH_W-1:0]  month,
   input  logic [cdo_pkg::YEAR_W-1:0]   year,
   input  logic [AMT_W-1:0]             amount,
   input  logic                         neg,
   input  logic [MAG_W-1:0]             quot,
   input  logic [cdo_pkg::DIVR_W-1:0]   rem,
   output logic [cdo_pkg::DAY_W-1:0]    new_day,
   output logic [cdo_pkg::MONTH_W-1:0]  new_month,
   output logic [cdo_pkg::YEAR_W-1:0]   new_year,
   output logic                         out_of_range
);

   localparam int TOT_W = MAG_W + 1;
   localparam logic signed [TOT_W-1:0] MIN_S = TOT_W'(MIN_YEAR);
   localparam logic signed [TOT_W-1:0] MAX_S = TOT_W'(MAX_YEAR);

   logic                        day_kind;
   logic                        is_sub;
   logic                        rem_nz;
   logic [cdo_pkg::DIVR_W-1:0]  divisor;
   logic [TOT_W-1:0]            quot_ext;
   logic [TOT_W-1:0]            q_fix;
   logic [cdo_pkg::DIVR_W-1:0]  r_fix;
   logic [cdo_pkg::MONTH_W-1:0] d_month;
   logic [cdo_pkg::DAY_W-1:0]   d_day;
   logic [cdo_pkg::MONTH_W-1:0] m_month;
   logic [cdo_pkg::DAY_W-1:0]   m_len;
   logic [cdo_pkg::DAY_W-1:0]   m_day;
   logic [TOT_W-1:0]            y_year;
   logic [TOT_W-1:0]            res_year;
   logic signed [TOT_W-1:0]     res_s;

   assign day_kind = (kind == cdo_pkg::KIND_ADD_DAYS) || (kind == cdo_pkg::KIND_SUB_DAYS);
   assign is_sub   = (kind == cdo_pkg::KIND_SUB_DAYS) || (kind == cdo_pkg::KIND_SUB_MONTHS) ||
                     (kind == cdo_pkg::KIND_SUB_YEARS);
   assign divisor  = day_kind ? cdo_pkg::DIVR_W'(cdo_pkg::DAYS_PER_YEAR)
                              : cdo_pkg::DIVR_W'(cdo_pkg::MONTHS_PER_YEAR);

   // floor division fix-up for a negative count
   assign rem_nz   = rem != '0;
   assign quot_ext = {1'b0, quot};
   assign q_fix    = neg ? (~quot_ext + TOT_W'(!rem_nz)) : quot_ext;
   assign r_fix    = (neg && rem_nz) ? (divisor - rem) : rem;

   // day of year to month and day
   always_comb begin
      logic [cdo_pkg::DIVR_W-1:0] offs;
      d_month = cdo_pkg::DECEMBER;
      for (int i = 12; i >= 2; i--) begin
         if (r_fix < cdo_pkg::month_start(cdo_pkg::MONTH_W'(i))) begin
            d_month = cdo_pkg::MONTH_W'(i - 1);
         end
      end
      offs  = r_fix - cdo_pkg::month_start(d_month) + 9'd1;
      d_day = offs[cdo_pkg::DAY_W-1:0];
   end

   // month index to month, day clamped to its length
   assign m_month = r_fix[cdo_pkg::MONTH_W-1:0] + cdo_pkg::JANUARY;
   assign m_len   = cdo_pkg::month_len(m_month);
   assign m_day   = (day > m_len) ? m_len : day;

   assign y_year  = is_sub ? (TOT_W'(year) - TOT_W'(amount)) : (TOT_W'(year) + TOT_W'(amount));

   always_comb begin
      new_day   = day;
      new_month = month;
      res_year  = TOT_W'(year);
      case (kind) inside
         cdo_pkg::KIND_ADD_DAYS, cdo_pkg::KIND_SUB_DAYS: begin
            new_day   = d_day;
            new_month = d_month;
            res_year  = q_fix;
         end
         cdo_pkg::KIND_ADD_MONTHS, cdo_pkg::KIND_SUB_MONTHS: begin
            new_day   = m_day;
            new_month = m_month;
            res_year  = q_fix;
         end
         cdo_pkg::KIND_ADD_YEARS, cdo_pkg::KIND_SUB_YEARS: begin
            res_year  = y_year;
         end
         default: begin
            res_year  = TOT_W'(year);
         end
      endcase
   end

   // saturate year and flag
   assign res_s = signed'(res_year);

   always_comb begin
      out_of_range = 1'b0;
      new_year     = res_year[cdo_pkg::YEAR_W-1:0];
      if (res_s < MIN_S) begin
         out_of_range = 1'b1;
         new_year     = cdo_pkg::YEAR_W'(MIN_YEAR);
      end else if (res_s > MAX_S) begin
         out_of_range = 1'b1;
         new_year     = cdo_pkg::YEAR_W'(MAX_YEAR);
      end
   end

endmodule

/* hw/rtl/calendar_date_offset.sv */
// ----------------------------------------------------------------------------
// calendar_date_offset
// sequence: prep, then load and div for day and month steps, div waiting on the four
//   steps of the reciprocal divider; year steps and unused kinds go straight to done
// throughput: one item in flight; the next item is accepted back in idle once done has
//   loaded its result, later while the output register is full and not being drained
// synchronous active-high reset idles the sequencer and empties the output
// ----------------------------------------------------------------------------
module calendar_date_offset #(
   parameter int MIN_YEAR    = cdo_pkg::MIN_YEAR_DEF,
   parameter int MAX_YEAR    = cdo_pkg::MAX_YEAR_DEF,
   parameter int AMOUNT_BITS = cdo_pkg::AMOUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   cdo_req_if.sink     req_if,
   cdo_rsp_if.source   rsp_if
);

   // amount bits that take part, never more than the field carries
   localparam int AMT_W = (AMOUNT_BITS < cdo_pkg::AMOUNT_W) ? AMOUNT_BITS : cdo_pkg::AMOUNT_W;
   // magnitude of a day or month count, one spare bit
   localparam int MAG_W = ((AMT_W > cdo_pkg::DAY_COUNT_W) ? AMT_W : cdo_pkg::DAY_COUNT_W) + 1;
   // signed count
   localparam int TOT_W = MAG_W + 1;

   cdo_pkg::cdo_state_type state_ff, state_in;

   // captured item, date already cleaned up
   logic [cdo_pkg::KIND_W-1:0]   kind_ff, kind_in;
   logic [cdo_pkg::DAY_W-1:0]    day_ff, day_in;
   logic [cdo_pkg::MONTH_W-1:0]  month_ff, month_in;
   logic [cdo_pkg::YEAR_W-1:0]   year_ff, year_in;
   logic [AMT_W-1:0]             amount_ff, amount_in;

   // signed day or month count and its sign
   logic [TOT_W-1:0]             total_ff, total_in;
   logic                         neg_ff, neg_in;

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [cdo_pkg::DAY_W-1:0]    rsp_day_ff, rsp_day_in;
   logic [cdo_pkg::MONTH_W-1:0]  rsp_month_ff, rsp_month_in;
   logic [cdo_pkg::YEAR_W-1:0]   rsp_year_ff, rsp_year_in;
   logic                         rsp_flag_ff, rsp_flag_in;

   logic                         accept;
   logic                         out_free;
   logic                         div_start;
   logic                         out_load;
   logic                         div_kind;
   logic                         day_kind;
   logic                         is_sub;

   logic [cdo_pkg::MONTH_W-1:0]  clean_month;
   logic [cdo_pkg::DAY_W-1:0]    clean_len;
   logic [cdo_pkg::DAY_W-1:0]    clean_day;
   logic [TOT_W-1:0]             base;
   logic [TOT_W-1:0]             count;
   logic [TOT_W-1:0]             abs_total;
   logic [cdo_pkg::DIVR_W-1:0]   divisor;

   logic                         div_done;
   logic [MAG_W-1:0]             div_quot;
   logic [cdo_pkg::DIVR_W-1:0]   div_rem;

   logic [cdo_pkg::DAY_W-1:0]    fin_day;
   logic [cdo_pkg::MONTH_W-1:0]  fin_month;
   logic [cdo_pkg::YEAR_W-1:0]   fin_year;
   logic                         fin_flag;

   assign accept   = req_if.valid && req_if.ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // kind decode on the captured item
   assign day_kind = (kind_ff == cdo_pkg::KIND_ADD_DAYS) || (kind_ff == cdo_pkg::KIND_SUB_DAYS);
   assign div_kind = day_kind || (kind_ff == cdo_pkg::KIND_ADD_MONTHS) ||
                     (kind_ff == cdo_pkg::KIND_SUB_MONTHS);
   assign is_sub   = (kind_ff == cdo_pkg::KIND_SUB_DAYS) ||
                     (kind_ff == cdo_pkg::KIND_SUB_MONTHS);
   assign divisor  = day_kind ? cdo_pkg::DIVR_W'(cdo_pkg::DAYS_PER_YEAR)
                              : cdo_pkg::DIVR_W'(cdo_pkg::MONTHS_PER_YEAR);

   // month zero reads as january, past december as december
   // day zero reads as the first, past the month's end as its last day
   always_comb begin
      if (req_if.month == '0) begin
         clean_month = cdo_pkg::JANUARY;
      end else if (req_if.month > cdo_pkg::DECEMBER) begin
         clean_month = cdo_pkg::DECEMBER;
      end else begin
         clean_month = req_if.month;
      end
      clean_len = cdo_pkg::month_len(clean_month);
      if (req_if.day == '0) begin
         clean_day = 5'd1;
      end else if (req_if.day > clean_len) begin
         clean_day = clean_len;
      end else begin
         clean_day = req_if.day;
      end
   end

   always_comb begin
      kind_in   = kind_ff;
      day_in    = day_ff;
      month_in  = month_ff;
      year_in   = year_ff;
      amount_in = amount_ff;
      if (accept) begin
         kind_in   = req_if.kind;
         day_in    = clean_day;
         month_in  = clean_month;
         year_in   = req_if.year;
         amount_in = req_if.amount[AMT_W-1:0];
      end
   end

   // day count from year zero, or month count from year zero
   always_comb begin
      if (day_kind) begin
         base = TOT_W'(year_ff) * TOT_W'(cdo_pkg::DAYS_PER_YEAR) +
                TOT_W'(cdo_pkg::month_start(month_ff)) + TOT_W'(day_ff) - TOT_W'(1);
      end else begin
         base = TOT_W'(year_ff) * TOT_W'(cdo_pkg::MONTHS_PER_YEAR) +
                TOT_W'(month_ff) - TOT_W'(1);
      end
      count = is_sub ? (base - TOT_W'(amount_ff)) : (base + TOT_W'(amount_ff));
   end

   assign total_in  = (state_ff == cdo_pkg::ST_PREP) ? count : total_ff;
   assign abs_total = total_ff[TOT_W-1] ? (~total_ff + TOT_W'(1)) : total_ff;
   assign neg_in    = div_start ? total_ff[TOT_W-1] : neg_ff;

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cdo_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = cdo_pkg::ST_PREP;
            end
         end
         cdo_pkg::ST_PREP: begin
            state_in = div_kind ? cdo_pkg::ST_LOAD : cdo_pkg::ST_DONE;
         end
         cdo_pkg::ST_LOAD: begin
            state_in = cdo_pkg::ST_DIV;
         end
         cdo_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = cdo_pkg::ST_DONE;
            end
         end
         cdo_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = cdo_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cdo_pkg::ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_if.ready = 1'b0;
      div_start    = 1'b0;
      out_load     = 1'b0;
      unique case (state_ff)
         cdo_pkg::ST_IDLE: req_if.ready = 1'b1;
         cdo_pkg::ST_LOAD: div_start    = 1'b1;
         cdo_pkg::ST_DONE: out_load     = out_free;
         default: begin
            req_if.ready = 1'b0;
         end
      endcase
   end

   // the shared divider splits a count into year and position in year
   cdo_divider #(
      .MAG_W     (MAG_W)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (abs_total[MAG_W-1:0]),
      .divisor   (divisor),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   cdo_finish #(
      .MAG_W        (MAG_W),
      .AMT_W        (AMT_W),
      .MIN_YEAR     (MIN_YEAR),
      .MAX_YEAR     (MAX_YEAR)
   ) u_finish (
      .kind         (kind_ff),
      .day          (day_ff),
      .month        (month_ff),
      .year         (year_ff),
      .amount       (amount_ff),
      .neg          (neg_ff),
      .quot         (div_quot),
      .rem          (div_rem),
      .new_day      (fin_day),
      .new_month    (fin_month),
      .new_year     (fin_year),
      .out_of_range (fin_flag)
   );

   // output register, loaded when empty or being drained
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_day_in   = rsp_day_ff;
      rsp_month_in = rsp_month_ff;
      rsp_year_in  = rsp_year_ff;
      rsp_flag_in  = rsp_flag_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_day_in   = fin_day;
         rsp_month_in = fin_month;
         rsp_year_in  = fin_year;
         rsp_flag_in  = fin_flag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cdo_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff      <= kind_in;
      day_ff       <= day_in;
      month_ff     <= month_in;
      year_ff      <= year_in;
      amount_ff    <= amount_in;
      total_ff     <= total_in;
      neg_ff       <= neg_in;
      rsp_day_ff   <= rsp_day_in;
      rsp_month_ff <= rsp_month_in;
      rsp_year_ff  <= rsp_year_in;
      rsp_flag_ff  <= rsp_flag_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.new_day      = rsp_day_ff;
   assign rsp_if.new_month    = rsp_month_ff;
   assign rsp_if.new_year     = rsp_year_ff;
   assign rsp_if.out_of_range = rsp_flag_ff;

endmodule

/* test/tb_calendar_date_offset.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_calendar_date_offset
// self-checking bench for the no-leap-year date offset block: a short table
// of corner items, then random dates, kinds and amounts. The random part is
// split into phases of sender gaps and receiver stalls, and every result is
// checked against a typed-in value or an in-bench date calculator.
// ----------------------------------------------------------------------------
module tb_calendar_date_offset;
   import cdo_pkg::*;

   // kinds the block treats as no operation
   localparam logic [KIND_W-1:0] KIND_NOP_LO = 3'd6;
   localparam logic [KIND_W-1:0] KIND_NOP_HI = 3'd7;

   localparam int YEAR_LO          = MIN_YEAR_DEF;
   localparam int YEAR_HI          = MAX_YEAR_DEF;
   localparam int DIR_N            = 25;
   localparam int RANDOM_PER_PHASE = 312;
   localparam int PHASE_N          = 4;
   // cycles without any handshake before the run is declared hung
   localparam int WATCHDOG_LIMIT   = 5000;
   // quiet cycles after the last result, well past the day-step latency
   localparam int TAIL_CYCLES      = 80;

   // table rows either carry a typed-in result or defer to the calculator
   localparam bit TYPED     = 1'b1;
   localparam bit PREDICTED = 1'b0;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [DAY_W-1:0]    day;
      logic [MONTH_W-1:0]  month;
      logic [YEAR_W-1:0]   year;
      logic [AMOUNT_W-1:0] amount;
   } date_cmd_type;

   typedef struct packed {
      logic [DAY_W-1:0]    day;
      logic [MONTH_W-1:0]  month;
      logic [YEAR_W-1:0]   year;
      logic                oor;
   } date_val_type;

   typedef struct packed {
      date_cmd_type cmd;
      logic         typed;
      date_val_type want;
   } dir_row_type;

   typedef struct packed {
      int           idx;
      date_val_type want;
   } pending_type;

   logic clock;
   logic reset;

   cdo_req_if req_ch ();
   cdo_rsp_if rsp_ch ();

   calendar_date_offset u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // dates still owed by the block, oldest first
   pending_type pending_dates [$];
   dir_row_type dir_rows [DIR_N];

   int items_sent;
   int results_seen;
   int error_count;
   int quiet_cycles;
   // chance in a hundred of a sender gap / receiver stall per cycle
   int idle_pct;
   int stall_pct;

   // clock, 2 ns period
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // date calculator
   // ---------------------------------------------------------------------

   // days of a month, february always 28
   function automatic int days_in(input int m);
      int len;
      case (m)
         2:             len = 28;
         4, 6, 9, 11:   len = 30;
         default:       len = 31;
      endcase
      return len;
   endfunction

   // day of year (from 0) of the first of month m
   function automatic int first_day(input int m);
      int s;
      int i;
      s = 0;
      for (i = 1; i < m; i++) s += days_in(i);
      return s;
   endfunction

   // division rounding toward minus infinity
   function automatic longint floor_div(input longint a, input longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q -= 1;
      return q;
   endfunction

   function automatic date_val_type offset_date(input date_cmd_type cmd);
      longint       d;
      longint       m;
      longint       y;
      longint       amt;
      longint       total;
      longint       doy;
      int           i;
      date_val_type res;
      d   = longint'(cmd.day);
      m   = longint'(cmd.month);
      y   = longint'(cmd.year);
      amt = longint'(cmd.amount);
      // clean up the starting date: month into 1..12, day into the month
      if (m < 1) m = 1;
      if (m > 12) m = 12;
      if (d < 1) d = 1;
      if (d > days_in(int'(m))) d = days_in(int'(m));
      case (cmd.kind)
         KIND_ADD_DAYS, KIND_SUB_DAYS: begin
            total = y * DAYS_PER_YEAR + first_day(int'(m)) + d - 1;
            total += (cmd.kind == KIND_ADD_DAYS) ? amt : -amt;
            y     = floor_div(total, DAYS_PER_YEAR);
            doy   = total - y * DAYS_PER_YEAR;
            // scan downward so the first month that holds doy wins
            m = 12;
            for (i = 12; i >= 1; i--) begin
               if (doy < first_day(i) + days_in(i)) m = i;
            end
            d = doy - first_day(int'(m)) + 1;
         end
         KIND_ADD_MONTHS, KIND_SUB_MONTHS: begin
            total = y * MONTHS_PER_YEAR + m - 1;
            total += (cmd.kind == KIND_ADD_MONTHS) ? amt : -amt;
            y     = floor_div(total, MONTHS_PER_YEAR);
            m     = total - y * MONTHS_PER_YEAR + 1;
            if (d > days_in(int'(m))) d = days_in(int'(m));
         end
         KIND_ADD_YEARS, KIND_SUB_YEARS: begin
            y += (cmd.kind == KIND_ADD_YEARS) ? amt : -amt;
         end
         default: begin
         end
      endcase
      res.oor = 1'b0;
      if (y < YEAR_LO) begin
         y       = YEAR_LO;
         res.oor = 1'b1;
      end else if (y > YEAR_HI) begin
         y       = YEAR_HI;
         res.oor = 1'b1;
      end
      res.day   = d[DAY_W-1:0];
      res.month = m[MONTH_W-1:0];
      res.year  = y[YEAR_W-1:0];
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   function automatic dir_row_type row(input logic [KIND_W-1:0] kind, input int day,
                                       input int month, input int year, input int amount,
                                       input bit typed, input int w_day, input int w_month,
                                       input int w_year, input int w_oor);
      dir_row_type r;
      r.cmd.kind   = kind;
      r.cmd.day    = day[DAY_W-1:0];
      r.cmd.month  = month[MONTH_W-1:0];
      r.cmd.year   = year[YEAR_W-1:0];
      r.cmd.amount = amount[AMOUNT_W-1:0];
      r.typed      = typed;
      r.want.day   = w_day[DAY_W-1:0];
      r.want.month = w_month[MONTH_W-1:0];
      r.want.year  = w_year[YEAR_W-1:0];
      r.want.oor   = w_oor[0];
      return r;
   endfunction

   // mostly valid dates with small amounts, some raw bit patterns
   function automatic date_cmd_type random_date_cmd();
      date_cmd_type c;
      int           size_class;
      if ($urandom_range(99) < 75) begin
         c.kind     = KIND_W'($urandom_range(5));
         c.month    = MONTH_W'($urandom_range(12, 1));
         c.day      = DAY_W'($urandom_range(days_in(int'(c.month)), 1));
         c.year     = YEAR_W'($urandom_range(YEAR_HI, YEAR_LO));
         size_class = int'($urandom_range(9));
         if (size_class < 5)       c.amount = AMOUNT_W'($urandom_range(40));
         else if (size_class < 8)  c.amount = AMOUNT_W'($urandom_range(1000));
         else if (size_class == 8) c.amount = AMOUNT_W'($urandom_range(20000));
         else                      c.amount = AMOUNT_W'($urandom_range(65535));
      end else begin
         // any bit pattern: unused kinds, day 0, month 0 and 13..15, any year
         c.kind   = KIND_W'($urandom_range(7));
         c.day    = DAY_W'($urandom_range(31));
         c.month  = MONTH_W'($urandom_range(15));
         c.year   = YEAR_W'($urandom_range(4095));
         c.amount = AMOUNT_W'($urandom_range(65535));
      end
      return c;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_date_cmd(input date_cmd_type cmd, input bit typed,
                                input date_val_type want);
      pending_type p;
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.kind   <= cmd.kind;
      req_ch.day    <= cmd.day;
      req_ch.month  <= cmd.month;
      req_ch.year   <= cmd.year;
      req_ch.amount <= cmd.amount;
      @(posedge clock);
      while (!(req_ch.valid && req_ch.ready)) @(posedge clock);
      // item taken at this edge, queue what it must turn into
      p.idx  = items_sent;
      p.want = typed ? want : offset_date(cmd);
      pending_dates.push_back(p);
      items_sent++;
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------------

   task automatic log_mismatch(input int idx, input string field, input int got,
                               input int want);
      $display("ERROR @%0t item %0d: %s got %0d want %0d", $realtime, idx, field,
               got, want);
      error_count++;
   endtask

   task automatic check_date_result();
      pending_type p;
      results_seen++;
      if (pending_dates.size() == 0) begin
         log_mismatch(-1, "result with nothing pending, new_day", rsp_ch.new_day, 0);
      end else begin
         p = pending_dates.pop_front();
         if (rsp_ch.new_day !== p.want.day)
            log_mismatch(p.idx, "new_day", rsp_ch.new_day, p.want.day);
         if (rsp_ch.new_month !== p.want.month)
            log_mismatch(p.idx, "new_month", rsp_ch.new_month, p.want.month);
         if (rsp_ch.new_year !== p.want.year)
            log_mismatch(p.idx, "new_year", rsp_ch.new_year, p.want.year);
         if (rsp_ch.out_of_range !== p.want.oor)
            log_mismatch(p.idx, "out_of_range", rsp_ch.out_of_range, p.want.oor);
      end
   endtask

   // result monitor and watchdog, both on the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles = quiet_cycles + 1;
         if (rsp_ch.valid && rsp_ch.ready) check_date_result();
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d items owed",
                     quiet_cycles, pending_dates.size());
            $display("tb_calendar_date_offset failed");
            $finish;
         end
      end
   end

   // receiver: ready toggled at the falling edge by the current stall rate
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      int n;
      int ph;
      reset         = 1'b1;
      req_ch.valid  = 1'b0;
      req_ch.kind   = '0;
      req_ch.day    = '0;
      req_ch.month  = '0;
      req_ch.year   = '0;
      req_ch.amount = '0;
      items_sent    = 0;
      results_seen  = 0;
      error_count   = 0;
      quiet_cycles  = 0;
      idle_pct      = 0;
      stall_pct     = 0;

      // corner items: kind, d, m, y, amount, then typed result or calculator
      dir_rows = '{
         // zero step from the earliest date
         row(KIND_ADD_DAYS,   1,  1, 1500,     0, TYPED,      1,  1, 1500, 0),
         // december to january
         row(KIND_ADD_DAYS,  31, 12, 2000,     1, TYPED,      1,  1, 2001, 0),
         row(KIND_SUB_DAYS,   1,  1, 2000,     1, TYPED,     31, 12, 1999, 0),
         // back across the end of february
         row(KIND_SUB_DAYS,   1,  3, 2000,     1, TYPED,     28,  2, 2000, 0),
         // a whole year of days
         row(KIND_ADD_DAYS,   5,  5, 2000,   365, PREDICTED,  0,  0,    0, 0),
         // largest amounts from the widest years and from a mid-range year
         row(KIND_ADD_DAYS,  31, 12, 4095, 65535, PREDICTED,  0,  0,    0, 0),
         row(KIND_SUB_DAYS,   1,  1,    0, 65535, PREDICTED,  0,  0,    0, 0),
         row(KIND_ADD_DAYS,  15,  6, 2000, 65535, PREDICTED,  0,  0,    0, 0),
         // month step clamps the day to the new month
         row(KIND_ADD_MONTHS, 31, 1, 2000,     1, TYPED,     28,  2, 2000, 0),
         row(KIND_ADD_MONTHS, 31, 3, 2000,    13, PREDICTED,  0,  0,    0, 0),
         // month wrap into the previous year, longer month steps, largest amounts
         row(KIND_SUB_MONTHS, 15, 1, 2000,     1, TYPED,     15, 12, 1999, 0),
         row(KIND_SUB_MONTHS, 31, 12, 2000,   10, PREDICTED,  0,  0,    0, 0),
         row(KIND_ADD_MONTHS, 15, 6, 4095, 65535, PREDICTED,  0,  0,    0, 0),
         row(KIND_SUB_MONTHS, 15, 6,    0, 65535, PREDICTED,  0,  0,    0, 0),
         // year steps up to and past both limits
         row(KIND_ADD_YEARS, 28,  2, 2000,  1000, TYPED,     28,  2, 3000, 0),
         row(KIND_ADD_YEARS,  1,  1, 3000,     1, TYPED,      1,  1, 3000, 1),
         row(KIND_SUB_YEARS,  1,  1, 1500,     1, TYPED,      1,  1, 1500, 1),
         row(KIND_SUB_YEARS, 10, 10, 2500,  1000, TYPED,     10, 10, 1500, 0),
         row(KIND_ADD_YEARS, 31, 12, 3000, 65535, TYPED,     31, 12, 3000, 1),
         row(KIND_SUB_YEARS,  1,  1, 1500, 65535, TYPED,      1,  1, 1500, 1),
         // unused kinds hand back the cleaned-up date, with the year clamp applied
         row(KIND_NOP_LO,     0,  0, 2000, 65535, TYPED,      1,  1, 2000, 0),
         row(KIND_NOP_HI,    31, 15, 4095,     0, TYPED,     31, 12, 3000, 1),
         // day past the month's length
         row(KIND_ADD_YEARS, 31,  4, 2000,     0, TYPED,     30,  4, 2000, 0),
         // out-of-range input year, clamp keeps day and month
         row(KIND_ADD_DAYS,  31,  2, 1499,     1, TYPED,      1,  3, 1500, 1),
         // day 0 and month 13
         row(KIND_SUB_DAYS,   0, 13, 2999,     0, TYPED,      1, 12, 2999, 0)
      };

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part, no gaps or stalls
      for (n = 0; n < DIR_N; n++)
         send_date_cmd(dir_rows[n].cmd, dir_rows[n].typed, dir_rows[n].want);

      // random part over four gap / stall mixes
      for (ph = 0; ph < PHASE_N; ph++) begin
         case (ph)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 75; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 75; end
            default: begin idle_pct = 36; stall_pct = 36; end
         endcase
         for (n = 0; n < RANDOM_PER_PHASE; n++)
            send_date_cmd(random_date_cmd(), PREDICTED, '0);
         req_ch.valid <= 1'b0;
         @(negedge clock);
         // sender holds off until every owed date is back
         while (pending_dates.size() != 0) @(negedge clock);
      end

      // any late or extra result would show up here
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("summary: %0d items (%0d table rows) sent, %0d results checked", items_sent,
               DIR_N, results_seen);
      $display("summary: day, month and year kinds, unused kinds, clamps; %0d errors",
               error_count);
      if (error_count == 0 && pending_dates.size() == 0) begin
         $display("tb_calendar_date_offset passed");
      end else begin
         $display("tb_calendar_date_offset failed");
      end
      $finish;
   end

endmodule
